### rtl/dmsr_pkg.sv
// Shared types and constants for the dual motor soft ramp block.
package dmsr_pkg;

   // Compare level encoding.
   localparam int unsigned LEVEL_W = 8;
   localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_IDLE = 8'd130;

   // Command byte layout.
   localparam int unsigned SPEED_W = 3;
   localparam int unsigned CMD_W   = 8;

   // Register widths and reset values.
   localparam int unsigned THR_W  = 10;
   localparam int unsigned STEP_W = 5;
   localparam logic [THR_W-1:0]  THR_RESET  = 10'd20;
   localparam logic [STEP_W-1:0] STEP_RESET = 5'd18;

   // Range sensor width default.
   localparam int unsigned RANGE_BITS_DEFAULT = 10;

   // Register port geometry.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes, taken from the word address bit.
   typedef enum logic {
      REG_THRESHOLD = 1'b0,
      REG_SPEED_STEP = 1'b1
   } reg_index_type;

   // Input transaction kinds.
   typedef enum logic {
      REQ_COMMAND = 1'b0,
      REQ_TICK    = 1'b1
   } req_kind_type;

   // Configuration values handed to the datapath.
   typedef struct packed {
      logic [THR_W-1:0]  threshold;
      logic [STEP_W-1:0] speed_step;
   } cfg_type;

   // Visible state of one motor side.
   typedef struct packed {
      logic [LEVEL_W-1:0] fwd_level;
      logic [LEVEL_W-1:0] rev_level;
      logic               is_forward;
   } side_state_type;

endpackage

### rtl/dual_motor_soft_ramp.sv
// Top level: input register, two motor sides, result register and register port.
// An accepted transaction waits in the input register until the result register is
// free; the result register then holds it until its result is taken.
// Throughput: one transaction per cycle unless stalled; input and result registers
// form a two-stage pipeline, and a result may wait while the input register fills.
// Reset (synchronous, active high) sets all levels off, goals idle, directions
// reverse, threshold 20 and speed step 18, and empties both stages.
module dual_motor_soft_ramp
   import dmsr_pkg::*;
#(
   parameter int unsigned RANGE_BITS = RANGE_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Input channel.
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [RANGE_BITS-1:0] req_forward_range,
   input  logic [RANGE_BITS-1:0] req_backward_range,
   // Result channel.
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [LEVEL_W-1:0]    rsp_right_fwd_duty,
   output logic [LEVEL_W-1:0]    rsp_right_rev_duty,
   output logic [LEVEL_W-1:0]    rsp_left_fwd_duty,
   output logic [LEVEL_W-1:0]    rsp_left_rev_duty,
   output logic                  rsp_right_is_forward,
   output logic                  rsp_left_is_forward,
   // Register port.
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   req_kind_type          s1_kind_ff;
   logic [CMD_W-1:0]      s1_cmd_ff;
   logic [RANGE_BITS-1:0] s1_fwd_ff;
   logic [RANGE_BITS-1:0] s1_bwd_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   side_state_type        right_ff;
   side_state_type        left_ff;

   side_state_type        right_next;
   side_state_type        left_next;
   cfg_type               cfg;
   logic                  out_free;
   logic                  advance;
   logic                  accept;

   // Pipeline handshake.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept ? 1'b1 : (out_free ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_free ? s1_valid_ff : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register captures the accepted transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= req_kind_type'(req_type);
         s1_cmd_ff  <= req_command;
         s1_fwd_ff  <= req_forward_range;
         s1_bwd_ff  <= req_backward_range;
      end
   end

   // Result register takes the updated side state.
   always_ff @(posedge clock) begin
      if (advance) begin
         right_ff <= right_next;
         left_ff  <= left_next;
      end
   end

   dmsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Right side uses the upper nibble of the command.
   dmsr_side #(.RANGE_BITS(RANGE_BITS)) u_right (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .kind       (s1_kind_ff),
      .speed      (s1_cmd_ff[6:4]),
      .dir_bit    (s1_cmd_ff[7]),
      .fwd_range  (s1_fwd_ff),
      .bwd_range  (s1_bwd_ff),
      .cfg        (cfg),
      .next_state (right_next)
   );

   // Left side uses the lower nibble of the command.
   dmsr_side #(.RANGE_BITS(RANGE_BITS)) u_left (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .kind       (s1_kind_ff),
      .speed      (s1_cmd_ff[2:0]),
      .dir_bit    (s1_cmd_ff[3]),
      .fwd_range  (s1_fwd_ff),
      .bwd_range  (s1_bwd_ff),
      .cfg        (cfg),
      .next_state (left_next)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_right_fwd_duty   = right_ff.fwd_level;
   assign rsp_right_rev_duty   = right_ff.rev_level;
   assign rsp_left_fwd_duty    = left_ff.fwd_level;
   assign rsp_left_rev_duty    = left_ff.rev_level;
   assign rsp_right_is_forward = right_ff.is_forward;
   assign rsp_left_is_forward  = left_ff.is_forward;

endmodule

### rtl/dmsr_csr.sv
// Register file for obstacle threshold and speed step, written over the APB-style port.
module dmsr_csr
   import dmsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [THR_W-1:0]  threshold_ff;
   logic [THR_W-1:0]  threshold_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              wr_en;
   reg_index_type     index;
   logic              aligned;

   assign pready  = 1'b1;
   assign index   = reg_index_type'(paddr[2]);
   assign aligned = (paddr[1:0] == 2'b00);
   assign wr_en   = psel && penable && pwrite;

   // Next register values on a write transaction.
   always_comb begin
      threshold_in = threshold_ff;
      step_in      = step_ff;
      if (wr_en) begin
         case (index)
            REG_THRESHOLD:  threshold_in = pwdata[THR_W-1:0];
            REG_SPEED_STEP: step_in      = pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
         step_ff      <= STEP_RESET;
      end else begin
         threshold_ff <= threshold_in;
         step_ff      <= step_in;
      end
   end

   // Read back; misaligned addresses return zero.
   always_comb begin
      prdata = '0;
      if (aligned) begin
         case (index)
            REG_THRESHOLD:  prdata = CSR_DATA_W'(threshold_ff);
            REG_SPEED_STEP: prdata = CSR_DATA_W'(step_ff);
            default:        prdata = '0;
         endcase
      end
   end

   assign cfg.threshold  = threshold_ff;
   assign cfg.speed_step = step_ff;

endmodule

### rtl/dmsr_side.sv
// State and combinational update logic for one motor side.
module dmsr_side
   import dmsr_pkg::*;
#(
   parameter int unsigned RANGE_BITS = RANGE_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  req_kind_type          kind,
   input  logic [SPEED_W-1:0]    speed,
   input  logic                  dir_bit,
   input  logic [RANGE_BITS-1:0] fwd_range,
   input  logic [RANGE_BITS-1:0] bwd_range,
   input  cfg_type               cfg,
   output side_state_type        next_state
);

   localparam int unsigned CMP_W = (RANGE_BITS > THR_W) ? RANGE_BITS : THR_W;

   logic [LEVEL_W-1:0] fwd_ff;
   logic [LEVEL_W-1:0] fwd_in;
   logic [LEVEL_W-1:0] rev_ff;
   logic [LEVEL_W-1:0] rev_in;
   logic [LEVEL_W-1:0] goal_ff;
   logic [LEVEL_W-1:0] goal_in;
   logic               dir_ff;
   logic               dir_in;

   logic [LEVEL_W-1:0] drop;
   logic [LEVEL_W-1:0] speed_level;
   logic [CMP_W-1:0]   range_sel;
   logic               blocked;
   logic [LEVEL_W-1:0] act;
   logic [LEVEL_W-1:0] opp;
   logic [LEVEL_W-1:0] act_start;
   logic [LEVEL_W-1:0] act_next;
   logic [LEVEL_W-1:0] opp_next;

   // Command decode: goal from speed times step, saturating at zero.
   assign drop        = LEVEL_W'(speed) * LEVEL_W'(cfg.speed_step);
   assign speed_level = (drop >= LEVEL_IDLE) ? '0 : (LEVEL_IDLE - drop);
   assign range_sel   = dir_bit ? CMP_W'(fwd_range) : CMP_W'(bwd_range);
   assign blocked     = (range_sel > CMP_W'(cfg.threshold));

   // Ramp step: the channel opposite the selected direction returns to off first.
   assign act       = dir_ff ? fwd_ff : rev_ff;
   assign opp       = dir_ff ? rev_ff : fwd_ff;
   assign act_start = (act == LEVEL_OFF) ? LEVEL_IDLE : act;

   always_comb begin
      act_next = act;
      opp_next = opp;
      if (opp == LEVEL_OFF) begin
         if (act_start > goal_ff) begin
            act_next = act_start - LEVEL_W'(1);
         end else if (act_start < goal_ff) begin
            act_next = act_start + LEVEL_W'(1);
         end else if (goal_ff == LEVEL_IDLE) begin
            act_next = LEVEL_OFF;
         end else begin
            act_next = act_start;
         end
      end else if (opp == LEVEL_IDLE) begin
         opp_next = LEVEL_OFF;
      end else begin
         opp_next = opp + LEVEL_W'(1);
      end
   end

   // Next state for the transaction at the output of the input register.
   always_comb begin
      fwd_in  = fwd_ff;
      rev_in  = rev_ff;
      goal_in = goal_ff;
      dir_in  = dir_ff;
      if (advance) begin
         case (kind)
            REQ_COMMAND: begin
               if (speed != '0) begin
                  dir_in = dir_bit;
               end
               goal_in = blocked ? LEVEL_IDLE :
                         ((speed != '0) ? speed_level : LEVEL_IDLE);
            end
            REQ_TICK: begin
               fwd_in = dir_ff ? act_next : opp_next;
               rev_in = dir_ff ? opp_next : act_next;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff  <= LEVEL_OFF;
         rev_ff  <= LEVEL_OFF;
         goal_ff <= LEVEL_IDLE;
         dir_ff  <= 1'b0;
      end else begin
         fwd_ff  <= fwd_in;
         rev_ff  <= rev_in;
         goal_ff <= goal_in;
         dir_ff  <= dir_in;
      end
   end

   assign next_state.fwd_level  = fwd_in;
   assign next_state.rev_level  = rev_in;
   assign next_state.is_forward = dir_in;

endmodule

### test/tb.sv
// Self-checking testbench for the dual motor soft ramp block.
`timescale 1ns / 1ps

module tb;
   import dmsr_pkg::*;

   localparam int unsigned RANGE_W = RANGE_BITS_DEFAULT;
   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned PHASES = 8;
   localparam int unsigned ITEMS_PER_PHASE = 240;

   // One input transaction as queued for the driver.
   typedef struct {
      req_kind_type       kind;
      logic [CMD_W-1:0]   command;
      logic [RANGE_W-1:0] fwd_range;
      logic [RANGE_W-1:0] bwd_range;
   } motor_req_type;

   // One result transaction: the four compare levels and both directions.
   typedef struct {
      logic [LEVEL_W-1:0] right_fwd;
      logic [LEVEL_W-1:0] right_rev;
      logic [LEVEL_W-1:0] left_fwd;
      logic [LEVEL_W-1:0] left_rev;
      logic               right_is_fwd;
      logic               left_is_fwd;
   } duty_result_type;

   // Predicted state of one motor side.
   typedef struct {
      logic [LEVEL_W-1:0] fwd;
      logic [LEVEL_W-1:0] rev;
      logic [LEVEL_W-1:0] goal;
      logic               dir;
   } side_pred_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_type = 1'b0;
   logic [CMD_W-1:0]      req_command = '0;
   logic [RANGE_W-1:0]    req_forward_range = '0;
   logic [RANGE_W-1:0]    req_backward_range = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]    rsp_right_fwd_duty;
   logic [LEVEL_W-1:0]    rsp_right_rev_duty;
   logic [LEVEL_W-1:0]    rsp_left_fwd_duty;
   logic [LEVEL_W-1:0]    rsp_left_rev_duty;
   logic                  rsp_right_is_forward;
   logic                  rsp_left_is_forward;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   dual_motor_soft_ramp #(.RANGE_BITS(RANGE_W)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_command(req_command),
      .req_forward_range(req_forward_range),
      .req_backward_range(req_backward_range),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_right_fwd_duty(rsp_right_fwd_duty),
      .rsp_right_rev_duty(rsp_right_rev_duty),
      .rsp_left_fwd_duty(rsp_left_fwd_duty),
      .rsp_left_rev_duty(rsp_left_rev_duty),
      .rsp_right_is_forward(rsp_right_is_forward),
      .rsp_left_is_forward(rsp_left_is_forward),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   motor_req_type   pending_reqs[$];
   duty_result_type expected_duties[$];
   side_pred_type   right_side = '{LEVEL_OFF, LEVEL_OFF, LEVEL_IDLE, 1'b0};
   side_pred_type   left_side = '{LEVEL_OFF, LEVEL_OFF, LEVEL_IDLE, 1'b0};
   logic [THR_W-1:0]  thr_cfg = THR_RESET;
   logic [STEP_W-1:0] step_cfg = STEP_RESET;
   int unsigned  send_idle_pct = 0;
   int unsigned  stall_pct = 0;
   int unsigned  fail_count = 0;
   int unsigned  quiet_cycles = 0;
   logic         req_fire = 1'b0;

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   // Goal and direction update of one side for a command byte.
   function automatic side_pred_type decode_command(side_pred_type s,
                                                    logic [SPEED_W-1:0] speed,
                                                    logic dir_bit, logic [RANGE_W-1:0] fr,
                                                    logic [RANGE_W-1:0] br);
      int unsigned        drop;
      logic [LEVEL_W-1:0] level;
      logic [RANGE_W-1:0] reading;
      level = LEVEL_IDLE;
      if (speed != 0) begin
         drop = int'(speed) * int'(step_cfg);
         level = (drop >= LEVEL_IDLE) ? '0 : LEVEL_W'(LEVEL_IDLE - drop);
         s.dir = dir_bit;
      end
      // The obstacle reading follows the commanded direction bit, even at speed zero.
      reading = dir_bit ? fr : br;
      s.goal = (reading > thr_cfg) ? LEVEL_IDLE : level;
      return s;
   endfunction

   // One ramp step: retire the opposite channel first, then move the active one.
   function automatic side_pred_type ramp_side(side_pred_type s);
      logic [LEVEL_W-1:0] act;
      logic [LEVEL_W-1:0] opp;
      act = s.dir ? s.fwd : s.rev;
      opp = s.dir ? s.rev : s.fwd;
      if (opp == LEVEL_OFF) begin
         if (act == LEVEL_OFF) act = LEVEL_IDLE;
         if (act > s.goal) act = act - 8'd1;
         else if (act < s.goal) act = act + 8'd1;
         else if (s.goal == LEVEL_IDLE) act = LEVEL_OFF;
      end else if (opp == LEVEL_IDLE) begin
         opp = LEVEL_OFF;
      end else begin
         opp = opp + 8'd1;
      end
      if (s.dir) begin
         s.fwd = act;
         s.rev = opp;
      end else begin
         s.rev = act;
         s.fwd = opp;
      end
      return s;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void push_req(req_kind_type kind, logic [CMD_W-1:0] cmd,
                                    logic [RANGE_W-1:0] fr, logic [RANGE_W-1:0] br);
      pending_reqs.push_back('{kind, cmd, fr, br});
   endfunction

   // Range reading that often sits at or near the threshold.
   function automatic logic [RANGE_W-1:0] pick_range();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 20) return (thr_cfg == '1) ? thr_cfg : thr_cfg + RANGE_W'($urandom_range(1));
      else if (roll < 65) return RANGE_W'($urandom_range(int'(thr_cfg)));
      else return RANGE_W'($urandom);
   endfunction

   // Input driver: a new transaction is presented only once the last one was taken.
   always @(negedge clock) begin
      motor_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_type <= item.kind;
            req_command <= item.command;
            req_forward_range <= item.fwd_range;
            req_backward_range <= item.bwd_range;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver stall.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Prediction, result checking and the watchdog, all sampled at the rising edge.
   always @(posedge clock) begin
      duty_result_type want;
      logic            req_take;
      logic            rsp_take;
      req_take = req_valid && !req_stall;
      rsp_take = rsp_valid && !rsp_stall;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_take;
         if (req_take) begin
            if (req_type == REQ_COMMAND) begin
               right_side = decode_command(right_side, req_command[6:4], req_command[7],
                                           req_forward_range, req_backward_range);
               left_side = decode_command(left_side, req_command[2:0], req_command[3],
                                          req_forward_range, req_backward_range);
            end else begin
               right_side = ramp_side(right_side);
               left_side = ramp_side(left_side);
            end
            expected_duties.push_back('{right_side.fwd, right_side.rev, left_side.fwd,
                                        left_side.rev, right_side.dir, left_side.dir});
         end
         if (rsp_take) begin
            if (expected_duties.size() == 0) begin
               $error("unexpected result transaction");
               fail_count++;
            end else begin
               want = expected_duties.pop_front();
               check_field("right_fwd_duty", want.right_fwd, rsp_right_fwd_duty);
               check_field("right_rev_duty", want.right_rev, rsp_right_rev_duty);
               check_field("left_fwd_duty", want.left_fwd, rsp_left_fwd_duty);
               check_field("left_rev_duty", want.left_rev, rsp_left_rev_duty);
               check_field("right_is_forward", want.right_is_fwd, rsp_right_is_forward);
               check_field("left_is_forward", want.left_is_fwd, rsp_left_is_forward);
            end
         end
         if (req_take || rsp_take || (psel && penable)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Register write: setup cycle, then access cycle until pready.
   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == REG_THRESHOLD) thr_cfg = value[THR_W-1:0];
      else step_cfg = value[STEP_W-1:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Wait until every queued transaction is taken and every result has arrived.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_duties.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic push_ticks(int unsigned count);
      repeat (count) push_req(REQ_TICK, CMD_W'($urandom), RANGE_W'($urandom),
                              RANGE_W'($urandom));
   endtask

   // Hand-picked sequence run at the reset configuration.
   task automatic queue_directed();
      push_ticks(1);                                   // tick from reset: idle goal turns off
      push_req(REQ_COMMAND, 8'hFF, '0, '0);            // full speed forward on both sides
      push_ticks(4);
      push_req(REQ_COMMAND, 8'h77, '0, '0);            // full speed reverse: forward ramps off
      push_ticks(3);
      push_req(REQ_COMMAND, 8'h88, '1, '1);            // speed zero keeps direction, blocked
      push_ticks(2);
      push_req(REQ_COMMAND, 8'h91, '1, '0);            // right blocked forward, left free
      push_ticks(2);
      push_req(REQ_COMMAND, 8'h19, 10'd21, 10'd20);    // readings on each side of threshold
      push_ticks(2);
      push_req(REQ_COMMAND, 8'h00, '1, '1);            // both sides back to idle
      push_ticks(4);
   endtask

   // Random traffic: mostly ticks so the levels ramp deep, with commands in between.
   task automatic queue_random(int unsigned cmd_pct);
      logic [CMD_W-1:0] cmd;
      repeat (ITEMS_PER_PHASE) begin
         if ($urandom_range(99) < cmd_pct) begin
            cmd = CMD_W'($urandom);
            push_req(REQ_COMMAND, cmd, pick_range(), pick_range());
         end else begin
            push_ticks(1);
         end
      end
   endtask

   // Main sequence: reset, then phases with their own settings and idle pattern.
   initial begin
      int unsigned thr_table[PHASES];
      int unsigned step_table[PHASES];
      thr_table = '{20, 0, 1023, 1023, 500, 0, 20, 1023};
      step_table = '{18, 0, 18, 31, 7, 18, 1, 13};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 54;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 54;
            end
            default: begin
               send_idle_pct = 32;
               stall_pct = 32;
            end
         endcase
         if (phase != 0) begin
            csr_write(REG_THRESHOLD, thr_table[phase]);
            csr_write(REG_SPEED_STEP, step_table[phase]);
         end else begin
            queue_directed();
         end
         queue_random((phase % 2 == 0) ? 15 : 4);
         wait_drained();
      end
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
